// File: hw/rtl/mci_pkg.sv
// mci_pkg: shared types, constants and saturating helpers for the monotone cubic
// interpolation pipeline. No dependencies.
package mci_pkg;

    localparam int QW        = 62;
    localparam int MUL_LAT   = 5;
    localparam int MUL_SPLIT = 31;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [QW+1:0] qx_t;

    localparam q_t QLIM = 62'sh1FFF_FFFF_FFFF_FFFF;

    function automatic q_t q_sat(input qx_t s);
        if (s > qx_t'(QLIM))
            return QLIM;
        if (s < -qx_t'(QLIM))
            return -QLIM;
        return s[QW-1:0];
    endfunction

    function automatic q_t q_add(input q_t a, input q_t b);
        return q_sat(qx_t'(a) + qx_t'(b));
    endfunction

    function automatic q_t q_sub(input q_t a, input q_t b);
        return q_sat(qx_t'(a) - qx_t'(b));
    endfunction

endpackage

// File: hw/rtl/mci_if.sv
// mci_in_if / mci_out_if: valid/ready item channels of the interpolation unit.
// No dependencies.
interface mci_in_if #(parameter int DATA_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  query_x;
    logic signed [DATA_WIDTH-1:0]  p0_x;
    logic signed [DATA_WIDTH-1:0]  p0_y;
    logic                          p0_y_present;
    logic signed [DATA_WIDTH-1:0]  p1_x;
    logic signed [DATA_WIDTH-1:0]  p1_y;
    logic signed [DATA_WIDTH-1:0]  p2_x;
    logic signed [DATA_WIDTH-1:0]  p2_y;
    logic signed [DATA_WIDTH-1:0]  p3_x;
    logic signed [DATA_WIDTH-1:0]  p3_y;
    logic                          p3_y_present;

    modport source (
        output valid, query_x, p0_x, p0_y, p0_y_present, p1_x, p1_y,
               p2_x, p2_y, p3_x, p3_y, p3_y_present,
        input  ready
    );
    modport sink (
        input  valid, query_x, p0_x, p0_y, p0_y_present, p1_x, p1_y,
               p2_x, p2_y, p3_x, p3_y, p3_y_present,
        output ready
    );
endinterface

interface mci_out_if #(parameter int DATA_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  interp_value;
    logic                          result_valid;
    logic                          saturated;

    modport source (
        output valid, interp_value, result_valid, saturated,
        input  ready
    );
    modport sink (
        input  valid, interp_value, result_valid, saturated,
        output ready
    );
endinterface

// File: hw/rtl/mci_delay.sv
// mci_delay: enabled shift line that keeps sideband data aligned with the
// arithmetic stages. No dependencies.
module mci_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

// File: hw/rtl/mci_mul.sv
// mci_mul: five-stage saturating fixed-point multiplier built from 31x31 partial
// products. Depends on mci_pkg.
module mci_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        en,
    input  mci_pkg::q_t a,
    input  mci_pkg::q_t b,
    output mci_pkg::q_t p
);
    localparam int QW = mci_pkg::QW;
    localparam int H  = mci_pkg::MUL_SPLIT;
    localparam int PW = 2 * H;
    localparam int MW = 2 * QW;

    logic [QW-1:0]  ua_reg, ub_reg;
    logic           n1_reg, n2_reg, n3_reg, n4_reg;
    logic [2*H-1:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic [2*H-1:0] pll3_reg, phh3_reg;
    logic [2*H:0]   mid_reg;
    logic [MW-1:0]  full_reg;
    mci_pkg::q_t    p_reg;

    logic [QW-1:0]  ua, ub;
    logic [MW-1:0]  sh;
    mci_pkg::q_t    mg;

    always_comb
    begin
        ua = a[QW-1] ? -a : a;
        ub = b[QW-1] ? -b : b;
        sh = full_reg >> FRAC_BITS;
        mg = (sh > MW'(mci_pkg::QLIM)) ? mci_pkg::QLIM : sh[QW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= ua;
            ub_reg   <= ub;
            n1_reg   <= a[QW-1] ^ b[QW-1];
            pll_reg  <= PW'(ua_reg[H-1:0])  * PW'(ub_reg[H-1:0]);
            plh_reg  <= PW'(ua_reg[H-1:0])  * PW'(ub_reg[QW-1:H]);
            phl_reg  <= PW'(ua_reg[QW-1:H]) * PW'(ub_reg[H-1:0]);
            phh_reg  <= PW'(ua_reg[QW-1:H]) * PW'(ub_reg[QW-1:H]);
            n2_reg   <= n1_reg;
            mid_reg  <= {1'b0, plh_reg} + {1'b0, phl_reg};
            pll3_reg <= pll_reg;
            phh3_reg <= phh_reg;
            n3_reg   <= n2_reg;
            full_reg <= {phh3_reg, pll3_reg} + (MW'(mid_reg) << H);
            n4_reg   <= n3_reg;
            p_reg    <= n4_reg ? -mg : mg;
        end
    end

    assign p = p_reg;
endmodule

// File: hw/rtl/mci_div.sv
// mci_div: pipelined restoring divider, one quotient bit per stage, giving the
// saturated Q quotient (num * 2^FRAC_BITS) / den. Depends on mci_pkg.
module mci_div #(
    parameter int DW        = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [DW:0] num,
    input  logic signed [DW:0] den,
    output mci_pkg::q_t        quo
);
    localparam int QW = mci_pkg::QW;
    localparam int NW = DW + 1 + FRAC_BITS;
    localparam int CW = (NW > QW) ? NW : QW;

    logic [DW:0]   r_reg [0:NW];
    logic [NW-1:0] n_reg [0:NW];
    logic [DW:0]   d_reg [0:NW];
    logic          s_reg [0:NW];
    mci_pkg::q_t   quo_reg;

    logic [DW:0]   un, ud;
    logic [CW-1:0] qx;
    mci_pkg::q_t   mg;

    always_comb
    begin
        un = num[DW] ? -num : num;
        ud = den[DW] ? -den : den;
        qx = CW'(n_reg[NW]);
        mg = (qx > CW'(mci_pkg::QLIM)) ? mci_pkg::QLIM : qx[QW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= '0;
            n_reg[0] <= {un, {FRAC_BITS{1'b0}}};
            d_reg[0] <= ud;
            s_reg[0] <= num[DW] ^ den[DW];
            quo_reg  <= s_reg[NW] ? -mg : mg;
        end
    end

    for (genvar i = 0; i < NW; i++)
    begin : g_step
        logic [DW+1:0] rr, rs;
        logic          ge;

        always_comb
        begin
            rr = {r_reg[i], n_reg[i][NW-1]};
            rs = rr - {1'b0, d_reg[i]};
            ge = rr >= {1'b0, d_reg[i]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1] <= ge ? rs[DW:0] : rr[DW:0];
                n_reg[i+1] <= {n_reg[i][NW-2:0], ge};
                d_reg[i+1] <= d_reg[i];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    assign quo = quo_reg;
endmodule

// File: hw/rtl/monotone_cubic_interpolation_unit.sv
// Monotone cubic Hermite interpolation unit: one query on four points per item.
// Depends on mci_pkg, mci_if, mci_delay, mci_div and mci_mul.
//
// Takes one item per clock while the pipeline advances and returns one result per
// item, in order. The depth is set mostly by the four slope/position dividers,
// which resolve one quotient bit per stage; the rest is the input register, three
// tangent stages, three chained five-stage multiplier levels, three saturating adds
// and the output register. The whole pipeline advances while the output register
// is empty or being taken, so in_ch.ready follows out_ch.ready.
// A zero x spacing in use returns result_valid = 0 with a zero value.
module monotone_cubic_interpolation_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mci_in_if.sink    in_ch,
    mci_out_if.source out_ch
);
    localparam int DW  = DATA_WIDTH;
    localparam int QW  = mci_pkg::QW;
    localparam int NW  = DW + 1 + FRAC_BITS;
    localparam int LD  = NW + 2;
    localparam int LM  = mci_pkg::MUL_LAT;
    localparam int LAT = LD + 8 + 3 * LM;

    typedef logic signed [DW:0]   diff_t;
    typedef logic signed [DW-1:0] val_t;

    localparam mci_pkg::q_t QONE   = mci_pkg::q_t'(1) << FRAC_BITS;
    localparam mci_pkg::q_t QTHREE = mci_pkg::q_t'(3) << FRAC_BITS;
    localparam mci_pkg::q_t OUT_HI =
        mci_pkg::q_t'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam mci_pkg::q_t OUT_LO = -OUT_HI - mci_pkg::q_t'(1);

    function automatic diff_t sub_x(input val_t a, input val_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

    function automatic mci_pkg::q_t tan_avg(input mci_pkg::q_t a, input mci_pkg::q_t b);
        logic signed [QW:0] s;
        logic signed [QW:0] hv;
        s  = $signed({a[QW-1], a}) + $signed({b[QW-1], b});
        hv = (s + $signed({{QW{1'b0}}, s[QW]})) >>> 1;
        if (a == '0 || b == '0)
            return '0;
        return hv[QW-1:0];
    endfunction

    function automatic mci_pkg::q_t tan_lim(input mci_pkg::q_t m, input mci_pkg::q_t d);
        logic [QW-1:0] mm, md;
        logic [QW+1:0] d3m;
        mci_pkg::qx_t  d3;
        mm  = m[QW-1] ? -m : m;
        md  = d[QW-1] ? -d : d;
        d3m = {2'b00, md} + {1'b0, md, 1'b0};
        d3  = mci_pkg::qx_t'(d) + mci_pkg::qx_t'($signed({d, 1'b0}));
        if (m == '0 || (m[QW-1] != d[QW-1]))
            return '0;
        if ({2'b00, mm} > d3m)
            return mci_pkg::q_sat(d3);
        return m;
    endfunction

    // handshake and valid tracking
    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    assign en          = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], in_ch.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // input stage: spacings and rises
    diff_t dy0_reg, dy1_reg, dy2_reg, h0_reg, h_reg, h2_reg, dx_reg;
    val_t  y1_reg, y2_reg;
    logic  has0_reg, has3_reg, inval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dy0_reg   <= sub_x(in_ch.p1_y, in_ch.p0_y);
            dy1_reg   <= sub_x(in_ch.p2_y, in_ch.p1_y);
            dy2_reg   <= sub_x(in_ch.p3_y, in_ch.p2_y);
            h0_reg    <= sub_x(in_ch.p1_x, in_ch.p0_x);
            h_reg     <= sub_x(in_ch.p2_x, in_ch.p1_x);
            h2_reg    <= sub_x(in_ch.p3_x, in_ch.p2_x);
            dx_reg    <= sub_x(in_ch.query_x, in_ch.p1_x);
            y1_reg    <= in_ch.p1_y;
            y2_reg    <= in_ch.p2_y;
            has0_reg  <= in_ch.p0_y_present;
            has3_reg  <= in_ch.p3_y_present;
            inval_reg <= (in_ch.p2_x == in_ch.p1_x)
                      || (in_ch.p0_y_present && (in_ch.p1_x == in_ch.p0_x))
                      || (in_ch.p3_y_present && (in_ch.p3_x == in_ch.p2_x));
        end
    end

    // slopes and position
    mci_pkg::q_t d0q, d1q, d2q, tq;

    mci_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_d0 (
        .clk(clk), .en(en), .num(dy0_reg), .den(h0_reg), .quo(d0q));
    mci_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_d1 (
        .clk(clk), .en(en), .num(dy1_reg), .den(h_reg), .quo(d1q));
    mci_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_d2 (
        .clk(clk), .en(en), .num(dy2_reg), .den(h2_reg), .quo(d2q));
    mci_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_t (
        .clk(clk), .en(en), .num(dx_reg), .den(h_reg), .quo(tq));

    logic  inval_a, has0_a, has3_a;
    val_t  y1_a, y2_a;
    diff_t h_a;

    mci_delay #(.WIDTH(3 * DW + 4), .DEPTH(LD)) u_dly_a (
        .clk(clk), .en(en),
        .d({inval_reg, has0_reg, has3_reg, y1_reg, y2_reg, h_reg}),
        .q({inval_a, has0_a, has3_a, y1_a, y2_a, h_a}));

    // tangents, limited against each neighbor in turn
    mci_pkg::q_t d0s, d2s;
    mci_pkg::q_t m1s_reg, m2s_reg, e0_reg, e1_reg, e2_reg;
    mci_pkg::q_t t1_reg, u1_reg, tt1_reg, tm1_reg;
    mci_pkg::q_t m1l_reg, m2l_reg, f0_reg, f1_reg, a1_2_reg, a3_2_reg;
    mci_pkg::q_t t2r_reg, u2r_reg, tm2_reg;
    mci_pkg::q_t m1_reg, m2_reg, t3_reg, u3_reg, a1_3_reg, a3_3_reg, tm3_reg;
    val_t        y1_1_reg, y2_1_reg, y1_2_reg, y2_2_reg, y1_3_reg, y2_3_reg;
    diff_t       h_1_reg, h_2_reg, h_3_reg;
    logic        iv_1_reg, iv_2_reg, iv_3_reg;

    always_comb
    begin
        d0s = has0_a ? d0q : d1q;
        d2s = has3_a ? d2q : d1q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1s_reg  <= tan_avg(d0s, d1q);
            m2s_reg  <= tan_avg(d1q, d2s);
            e0_reg   <= d0s;
            e1_reg   <= d1q;
            e2_reg   <= d2s;
            t1_reg   <= tq;
            u1_reg   <= mci_pkg::q_sub(QONE, tq);
            tt1_reg  <= mci_pkg::q_add(tq, tq);
            tm1_reg  <= mci_pkg::q_sub(tq, QONE);
            y1_1_reg <= y1_a;
            y2_1_reg <= y2_a;
            h_1_reg  <= h_a;
            iv_1_reg <= inval_a;

            m1l_reg  <= tan_lim(m1s_reg, e1_reg);
            m2l_reg  <= tan_lim(m2s_reg, e2_reg);
            f0_reg   <= e0_reg;
            f1_reg   <= e1_reg;
            a1_2_reg <= mci_pkg::q_add(QONE, tt1_reg);
            a3_2_reg <= mci_pkg::q_sub(QTHREE, tt1_reg);
            t2r_reg  <= t1_reg;
            u2r_reg  <= u1_reg;
            tm2_reg  <= tm1_reg;
            y1_2_reg <= y1_1_reg;
            y2_2_reg <= y2_1_reg;
            h_2_reg  <= h_1_reg;
            iv_2_reg <= iv_1_reg;

            m1_reg   <= tan_lim(m1l_reg, f0_reg);
            m2_reg   <= tan_lim(m2l_reg, f1_reg);
            t3_reg   <= t2r_reg;
            u3_reg   <= u2r_reg;
            a1_3_reg <= a1_2_reg;
            a3_3_reg <= a3_2_reg;
            tm3_reg  <= tm2_reg;
            y1_3_reg <= y1_2_reg;
            y2_3_reg <= y2_2_reg;
            h_3_reg  <= h_2_reg;
            iv_3_reg <= iv_2_reg;
        end
    end

    // Hermite basis products
    mci_pkg::q_t t2q, u2q, hm1q, hm2q;
    mci_pkg::q_t a1_e, a3_e, t_e, tm_e;
    val_t        y1_e, y2_e;
    logic        inval_e;

    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_tt (
        .clk(clk), .en(en), .a(t3_reg), .b(t3_reg), .p(t2q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uu (
        .clk(clk), .en(en), .a(u3_reg), .b(u3_reg), .p(u2q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hm1 (
        .clk(clk), .en(en), .a(mci_pkg::q_t'(h_3_reg)), .b(m1_reg), .p(hm1q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hm2 (
        .clk(clk), .en(en), .a(mci_pkg::q_t'(h_3_reg)), .b(m2_reg), .p(hm2q));

    mci_delay #(.WIDTH(1 + 2 * DW + 4 * QW), .DEPTH(LM)) u_dly_b (
        .clk(clk), .en(en),
        .d({iv_3_reg, y1_3_reg, y2_3_reg, a1_3_reg, a3_3_reg, t3_reg, tm3_reg}),
        .q({inval_e, y1_e, y2_e, a1_e, a3_e, t_e, tm_e}));

    mci_pkg::q_t b1q, b2q, b3q, b4q, hm1_f, hm2_f;
    val_t        y1_f, y2_f;
    logic        inval_f;

    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b1 (
        .clk(clk), .en(en), .a(a1_e), .b(u2q), .p(b1q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b2 (
        .clk(clk), .en(en), .a(t_e), .b(u2q), .p(b2q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b3 (
        .clk(clk), .en(en), .a(t2q), .b(a3_e), .p(b3q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b4 (
        .clk(clk), .en(en), .a(t2q), .b(tm_e), .p(b4q));

    mci_delay #(.WIDTH(1 + 2 * DW + 2 * QW), .DEPTH(LM)) u_dly_c (
        .clk(clk), .en(en),
        .d({inval_e, y1_e, y2_e, hm1q, hm2q}),
        .q({inval_f, y1_f, y2_f, hm1_f, hm2_f}));

    mci_pkg::q_t c1q, c2q, c3q, c4q;
    logic        inval_g;

    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_c1 (
        .clk(clk), .en(en), .a(mci_pkg::q_t'(y1_f)), .b(b1q), .p(c1q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_c2 (
        .clk(clk), .en(en), .a(hm1_f), .b(b2q), .p(c2q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_c3 (
        .clk(clk), .en(en), .a(mci_pkg::q_t'(y2_f)), .b(b3q), .p(c3q));
    mci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_c4 (
        .clk(clk), .en(en), .a(hm2_f), .b(b4q), .p(c4q));

    mci_delay #(.WIDTH(1), .DEPTH(LM)) u_dly_d (
        .clk(clk), .en(en), .d(inval_f), .q(inval_g));

    // accumulate in order, then clamp to the output range
    mci_pkg::q_t s1_reg, s2_reg, s3_reg, c3a_reg, c4a_reg, c4b_reg;
    logic        iv_s1_reg, iv_s2_reg, iv_s3_reg;
    val_t        val_reg;
    logic        ok_reg, sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= mci_pkg::q_add(c1q, c2q);
            c3a_reg   <= c3q;
            c4a_reg   <= c4q;
            iv_s1_reg <= inval_g;
            s2_reg    <= mci_pkg::q_add(s1_reg, c3a_reg);
            c4b_reg   <= c4a_reg;
            iv_s2_reg <= iv_s1_reg;
            s3_reg    <= mci_pkg::q_add(s2_reg, c4b_reg);
            iv_s3_reg <= iv_s2_reg;
            if (iv_s3_reg)
            begin
                val_reg <= '0;
                ok_reg  <= 1'b0;
                sat_reg <= 1'b0;
            end
            else if (s3_reg > OUT_HI)
            begin
                val_reg <= OUT_HI[DW-1:0];
                ok_reg  <= 1'b1;
                sat_reg <= 1'b1;
            end
            else if (s3_reg < OUT_LO)
            begin
                val_reg <= OUT_LO[DW-1:0];
                ok_reg  <= 1'b1;
                sat_reg <= 1'b1;
            end
            else
            begin
                val_reg <= s3_reg[DW-1:0];
                ok_reg  <= 1'b1;
                sat_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid        = vld_reg[LAT-1];
    assign out_ch.interp_value = val_reg;
    assign out_ch.result_valid = ok_reg;
    assign out_ch.saturated    = sat_reg;
endmodule
